// ===== rtl/core/range_tnum_witness_finder_macros.svh =====
// Assertion macros shared by the checker.
`ifndef RANGE_TNUM_WITNESS_FINDER_MACROS_SVH
`define RANGE_TNUM_WITNESS_FINDER_MACROS_SVH

`define RTWF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RTWF_ASSERT_RESET(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rtwf_pkg.sv =====
package rtwf_pkg;

    localparam logic [63:0] HI_HALF = 64'hFFFF_FFFF_0000_0000;
    localparam logic [63:0] ALL64   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ALL32   = 32'hFFFF_FFFF;
    localparam logic [63:0] SUB32   = 64'h1_0000_0000;
    localparam int unsigned NUM_PAIRS = 4;

    typedef struct packed {
        logic [63:0] range64_base;
        logic [63:0] range64_size;
        logic [31:0] range32_base;
        logic [31:0] range32_size;
        logic [63:0] known_value;
        logic [63:0] unknown_mask;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [63:0] witness;
    } out_beat_t;

    typedef struct packed {
        logic        en;
        logic [63:0] amin;
        logic [63:0] amax;
        logic [31:0] bmin;
        logic [31:0] bmax;
    } pair_t;

    typedef struct packed {
        logic [63:0] tv;
        logic [63:0] tm;
    } tnum_t;

    function automatic logic [63:0] lead_mask(input logic [63:0] v);
        logic [63:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
        return m;
    endfunction

    function automatic logic [63:0] t_next(input tnum_t t, input logic [63:0] z);
        logic [63:0] top;
        logic [63:0] d;
        logic [63:0] fill;
        top = t.tv | t.tm;
        d = z - t.tv;
        fill = d | lead_mask(d & ~t.tm) | ~t.tm;
        if (z >= top) begin
            return top;
        end
        if (z < t.tv) begin
            return t.tv;
        end
        return t.tv | ((fill + 64'd1) & t.tm);
    endfunction

    function automatic logic [63:0] settle(input tnum_t t, input logic [63:0] w);
        if ((w & ~t.tm) == t.tv) begin
            return w;
        end
        return t_next(t, w);
    endfunction

    function automatic logic in32(input logic [63:0] w, input logic [31:0] lo,
                                  input logic [31:0] hi);
        return (lo <= w[31:0]) && (w[31:0] <= hi);
    endfunction

endpackage

// ===== rtl/core/range_tnum_witness_finder.sv =====
// Range and tristate witness finder.
// Input channel in_valid/in_ready carries one query beat: a 64-bit circular
// range, a 32-bit circular range on the low half and a tristate number.
// Output channel out_valid/out_ready carries one result beat per query:
// found and a 64-bit witness, zero when nothing was found.
// The datapath is a four-stage pipeline; each of the four interval pairings
// has its own search unit, and a final stage picks the first pairing that hit.
// Throughput is one beat per cycle while the output is not stalled.
// When the output stage is full and the receiver holds out_ready low, the
// whole pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block then accepts a query at once.
module range_tnum_witness_finder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtwf_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rtwf_pkg::out_beat_t   out_data
);
    import rtwf_pkg::*;

    localparam int unsigned DEPTH = 4;

    pair_t       pairs [NUM_PAIRS];
    tnum_t       tn;
    logic        ok   [NUM_PAIRS];
    logic [63:0] w    [NUM_PAIRS];
    logic        advance;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    out_beat_t   res_reg;

    assign advance   = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = res_reg;
    assign vld_next  = {vld_reg[DEPTH-2:0], in_valid};

    rtwf_split u_split (
        .beat  (in_data),
        .pairs (pairs),
        .tn    (tn)
    );

    for (genvar g = 0; g < NUM_PAIRS; g++)
    begin : g_pair
        rtwf_pair u_pair (
            .clk     (clk),
            .advance (advance),
            .pair    (pairs[g]),
            .tn      (tn),
            .ok      (ok[g]),
            .w       (w[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.found <= ok[0] || ok[1] || ok[2] || ok[3];
            if (ok[0])
            begin
                res_reg.witness <= w[0];
            end
            else if (ok[1])
            begin
                res_reg.witness <= w[1];
            end
            else if (ok[2])
            begin
                res_reg.witness <= w[2];
            end
            else if (ok[3])
            begin
                res_reg.witness <= w[3];
            end
            else
            begin
                res_reg.witness <= '0;
            end
        end
    end
endmodule

// ===== rtl/core/rtwf_split.sv =====
module rtwf_split (
    input  rtwf_pkg::in_beat_t beat,
    output rtwf_pkg::pair_t    pairs [rtwf_pkg::NUM_PAIRS],
    output rtwf_pkg::tnum_t    tn
);
    import rtwf_pkg::*;

    logic        empty;
    logic [63:0] a1hi;
    logic [31:0] c1hi;
    logic        sp64;
    logic        sp32;

    always_comb
    begin
        empty = ((beat.range64_base == ALL64) && (beat.range64_size == ALL64))
             || ((beat.range32_base == ALL32) && (beat.range32_size == ALL32));
        a1hi = beat.range64_base + beat.range64_size;
        c1hi = beat.range32_base + beat.range32_size;
        sp64 = a1hi < beat.range64_base;
        sp32 = c1hi < beat.range32_base;
        tn.tv = beat.known_value;
        tn.tm = beat.unknown_mask;
        pairs[0].en   = !empty;
        pairs[0].amin = beat.range64_base;
        pairs[0].amax = sp64 ? ALL64 : a1hi;
        pairs[0].bmin = beat.range32_base;
        pairs[0].bmax = sp32 ? ALL32 : c1hi;
        pairs[1].en   = !empty && sp32;
        pairs[1].amin = pairs[0].amin;
        pairs[1].amax = pairs[0].amax;
        pairs[1].bmin = '0;
        pairs[1].bmax = c1hi;
        pairs[2].en   = !empty && sp64;
        pairs[2].amin = '0;
        pairs[2].amax = a1hi;
        pairs[2].bmin = pairs[0].bmin;
        pairs[2].bmax = pairs[0].bmax;
        pairs[3].en   = !empty && sp64 && sp32;
        pairs[3].amin = '0;
        pairs[3].amax = a1hi;
        pairs[3].bmin = '0;
        pairs[3].bmax = c1hi;
    end
endmodule

// ===== rtl/core/rtwf_pair.sv =====
module rtwf_pair (
    input  logic               clk,
    input  logic               advance,
    input  rtwf_pkg::pair_t    pair,
    input  rtwf_pkg::tnum_t    tn,
    output logic               ok,
    output logic [63:0]        w
);
    import rtwf_pkg::*;

    // Stage A: candidate starting points and guards.
    logic        en_reg;
    logic [63:0] amax_reg;
    logic [31:0] bmin_reg;
    logic [31:0] bmax_reg;
    logic [63:0] xh_reg;
    logic [63:0] yh_reg;
    logic        single_reg;
    logic        l_ok_reg;
    logic        mid_ok_reg;
    logic        r_ok_reg;
    logic [63:0] sx_reg;
    logic [63:0] sm_reg;
    logic [63:0] sy_reg;
    tnum_t       tn_reg;

    // Stage B: first settle results.
    logic        en2_reg;
    logic        single2_reg;
    logic        l_ok2_reg;
    logic        mid_ok2_reg;
    logic        r_ok2_reg;
    logic [63:0] amax2_reg;
    logic [31:0] bmin2_reg;
    logic [31:0] bmax2_reg;
    logic [63:0] xh2_reg;
    logic [63:0] yh2_reg;
    logic [63:0] wl_reg;
    logic [63:0] wm_reg;
    logic [63:0] wr_reg;
    tnum_t       tn2_reg;

    logic [31:0] l_val;
    logic [31:0] r_val;
    logic [63:0] xh;
    logic [63:0] yh;
    logic [63:0] wm_fix;
    logic [63:0] wm2;
    logic        hit_l;
    logic        hit_m;
    logic        hit_r;

    always_comb
    begin
        xh = pair.amin & HI_HALF;
        yh = pair.amax & HI_HALF;
        l_val = (pair.amin[31:0] > pair.bmin) ? pair.amin[31:0] : pair.bmin;
        r_val = (pair.amax[31:0] < pair.bmax) ? pair.amax[31:0] : pair.bmax;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            en_reg     <= pair.en && ((tn.tv | tn.tm) >= pair.amin);
            amax_reg   <= pair.amax;
            bmin_reg   <= pair.bmin;
            bmax_reg   <= pair.bmax;
            xh_reg     <= xh;
            yh_reg     <= yh;
            single_reg <= (xh == yh);
            l_ok_reg   <= (xh == yh) ? (l_val <= r_val) : (l_val <= pair.bmax);
            mid_ok_reg <= (xh + SUB32) < yh;
            r_ok_reg   <= pair.bmin <= r_val;
            sx_reg     <= xh | {32'd0, l_val};
            sm_reg     <= xh + SUB32;
            sy_reg     <= yh | {32'd0, pair.bmin};
            tn_reg     <= tn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            en2_reg     <= en_reg;
            single2_reg <= single_reg;
            l_ok2_reg   <= l_ok_reg;
            mid_ok2_reg <= mid_ok_reg;
            r_ok2_reg   <= r_ok_reg;
            amax2_reg   <= amax_reg;
            bmin2_reg   <= bmin_reg;
            bmax2_reg   <= bmax_reg;
            xh2_reg     <= xh_reg;
            yh2_reg     <= yh_reg;
            wl_reg      <= settle(tn_reg, sx_reg);
            wm_reg      <= settle(tn_reg, sm_reg);
            wr_reg      <= settle(tn_reg, sy_reg);
            tn2_reg     <= tn_reg;
        end
    end

    always_comb
    begin
        wm_fix = (wm_reg[31:0] < bmin2_reg) ? ((wm_reg & HI_HALF) | {32'd0, bmin2_reg})
                                            : wm_reg;
        wm2 = settle(tn2_reg, wm_fix);
        hit_l = l_ok2_reg && in32(wl_reg, bmin2_reg, bmax2_reg)
             && (single2_reg ? (wl_reg <= amax2_reg) : (wl_reg <= (xh2_reg | {32'd0, ALL32})));
        hit_m = !single2_reg && mid_ok2_reg && (wm2 < yh2_reg)
             && in32(wm2, bmin2_reg, bmax2_reg);
        hit_r = !single2_reg && r_ok2_reg && (wr_reg <= amax2_reg)
             && in32(wr_reg, bmin2_reg, bmax2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok <= en2_reg && (hit_l || hit_m || hit_r);
            w  <= hit_l ? wl_reg : (hit_m ? wm2 : wr_reg);
        end
    end
endmodule

// ===== rtl/core/rtwf_checker.sv =====
`include "range_tnum_witness_finder_macros.svh"

module rtwf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rtwf_pkg::out_beat_t out_data
);
    import rtwf_pkg::*;

    logic miss;
    logic stall;

    assign miss  = out_valid && !out_data.found;
    assign stall = out_valid && !out_ready;

    `RTWF_ASSERT_RESET(a_reset_empty, clk, rst_n, !rst_n |-> !out_valid, "out_valid in reset")
    `RTWF_ASSERT_IMPL(a_miss_zero, clk, rst_n, miss |-> out_data.witness == '0, "nonzero miss")
    `RTWF_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input blocked")
    `RTWF_ASSERT_IMPL(a_hold, clk, rst_n, stall |=> out_valid && $stable(out_data), "beat changed")
endmodule

bind range_tnum_witness_finder rtwf_checker u_rtwf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
